FILE: rtl/xcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_pkg: shared types and constants of the frame deframer
// Buffer geometry, frame offsets, register indexes and the structs that
// travel between the front part and the parser.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  // frame geometry
  localparam int unsigned MAX_LEN     = 32;
  localparam int unsigned MIN_FRAME   = 6;
  localparam int unsigned STORE_DEPTH = MAX_LEN + MIN_FRAME;

  // field widths of a result
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned IDX_W  = 5;

  // receive buffer ram, a ring addressed by base plus offset
  localparam int unsigned RAM_AW    = 6;
  localparam int unsigned RAM_DEPTH = 1 << RAM_AW;

  // input queue between front and parser
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef logic [RAM_AW-1:0] ptr_t;

  // sized forms of the frame constants
  localparam ptr_t MIN_FRAME_P   = ptr_t'(MIN_FRAME);
  localparam ptr_t STORE_DEPTH_P = ptr_t'(STORE_DEPTH);
  localparam ptr_t MAX_LEN_P     = ptr_t'(MAX_LEN);
  localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_LEN);
  localparam ptr_t HDR_BYTES_P   = ptr_t'(2);
  localparam ptr_t TYPE_LEN_END_P = ptr_t'(4);
  localparam ptr_t OFS_TYPE_P    = ptr_t'(2);
  localparam ptr_t OFS_LEN_P     = ptr_t'(3);
  localparam ptr_t OFS_PAYLOAD_P = ptr_t'(4);

  // register reset values
  localparam logic [BYTE_W-1:0] HEAD_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] HEAD_SECOND_RST = 8'd85;
  localparam logic [BYTE_W-1:0] TAIL_VALUE_RST  = 8'd255;

  typedef enum logic [1:0] {
    REG_HEAD_FIRST  = 2'd0,
    REG_HEAD_SECOND = 2'd1,
    REG_TAIL_VALUE  = 2'd2
  } reg_idx_t;

  // one queued received byte with its tail tag
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              is_tail;
  } qent_t;

  // configuration seen by the parser
  typedef struct packed {
    logic [BYTE_W-1:0] head_first;
    logic [BYTE_W-1:0] head_second;
    logic [BYTE_W-1:0] tail_value;
    logic              wr;
  } cfg_t;

  // one result
  typedef struct packed {
    logic [BYTE_W-1:0] frame_type;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              has_payload;
    logic              frame_status;
    logic              last_of_frame;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/xor_checked_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer: byte-serial deframer with xor check
// Frames are HEAD1 HEAD2 TYPE LEN PAYLOAD CHECK TAIL; good frames give one
// result per payload byte (one if empty), check mismatches one error result.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | carries
//   ---------+------------------------+--------------------------------------
//   in_      | in_valid / in_ready    | rx_byte
//   out_     | out_valid / out_ready  | frame_type .. last_of_frame
//   config   | psel penable pwrite    | head_first, head_second, tail_value
//
// The parser appends queued bytes only while idle; a 4-entry queue in front
// absorbs bursts. A header hunt reads buffered bytes until a header is found
// or the buffer runs out; type and length follow, then the tail. The check
// pass reads payload and check byte; emission gives len results (one for an
// error or an empty frame), one result per cycle while results are taken.
// The steps share the single read port of the receive buffer ram.
// Reset is synchronous; the buffer needs no clearing pass. Both sides stall
// independently through the queue and the output register.
//
module xor_checked_frame_deframer (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [7:0]                    in_rx_byte,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [7:0]                   out_frame_type,
  output logic [5:0]                   out_frame_length,
  output logic [7:0]                   out_payload_byte,
  output logic [4:0]                   out_byte_index,
  output logic                         out_has_payload,
  output logic                         out_frame_status,
  output logic                         out_last_of_frame,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [xcfd_pkg::APB_AW-1:0]   paddr,
  input  wire [xcfd_pkg::APB_DW-1:0]   pwdata,
  output logic [xcfd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  xcfd_pkg::cfg_t    cfg;
  xcfd_pkg::qent_t   q_head;
  xcfd_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;

  // intake and registers
  xcfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  // parser
  xcfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // result fields
  assign out_frame_type    = res.frame_type;
  assign out_frame_length  = res.frame_length;
  assign out_payload_byte  = res.payload_byte;
  assign out_byte_index    = res.byte_index;
  assign out_has_payload   = res.has_payload;
  assign out_frame_status  = res.frame_status;
  assign out_last_of_frame = res.last_of_frame;

endmodule
`default_nettype wire

FILE: rtl/xcfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module xcfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire             clk,
  input  wire             we,
  input  wire [AW-1:0]    waddr,
  input  wire [WIDTH-1:0] wdata,
  input  wire             re,
  input  wire [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/xcfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_front: request intake and configuration registers
// Holds the header and tail registers, tags each received byte against the
// tail value and queues it for the parser.
// ----------------------------------------------------------------------------
module xcfd_front (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [xcfd_pkg::BYTE_W-1:0]   in_rx_byte,
  // configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [xcfd_pkg::APB_AW-1:0]   paddr,
  input  wire [xcfd_pkg::APB_DW-1:0]   pwdata,
  output logic [xcfd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  // toward the parser
  output xcfd_pkg::cfg_t               cfg,
  output logic                         q_valid,
  output xcfd_pkg::qent_t              q_head,
  input  wire                          q_pop
);

  logic [xcfd_pkg::BYTE_W-1:0] head_first_r, head_second_r, tail_value_r;
  logic [xcfd_pkg::BYTE_W-1:0] head_first_nxt, head_second_nxt, tail_value_nxt;
  xcfd_pkg::qent_t             qmem_r [xcfd_pkg::QUEUE_DEPTH];
  logic [xcfd_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [xcfd_pkg::QUEUE_AW:0]   cnt_r;
  logic                        apb_wr;
  logic                        push;
  xcfd_pkg::reg_idx_t          reg_idx;

  assign reg_idx = xcfd_pkg::reg_idx_t'(paddr[xcfd_pkg::APB_AW-1:2]);
  assign apb_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register write decode
  always_comb begin
    head_first_nxt  = head_first_r;
    head_second_nxt = head_second_r;
    tail_value_nxt  = tail_value_r;
    if (apb_wr) begin
      unique case (reg_idx)
        xcfd_pkg::REG_HEAD_FIRST:  head_first_nxt  = pwdata[xcfd_pkg::BYTE_W-1:0];
        xcfd_pkg::REG_HEAD_SECOND: head_second_nxt = pwdata[xcfd_pkg::BYTE_W-1:0];
        xcfd_pkg::REG_TAIL_VALUE:  tail_value_nxt  = pwdata[xcfd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_idx)
      xcfd_pkg::REG_HEAD_FIRST:  prdata = xcfd_pkg::APB_DW'(head_first_r);
      xcfd_pkg::REG_HEAD_SECOND: prdata = xcfd_pkg::APB_DW'(head_second_r);
      xcfd_pkg::REG_TAIL_VALUE:  prdata = xcfd_pkg::APB_DW'(tail_value_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_first_r  <= xcfd_pkg::HEAD_FIRST_RST;
      head_second_r <= xcfd_pkg::HEAD_SECOND_RST;
      tail_value_r  <= xcfd_pkg::TAIL_VALUE_RST;
    end else begin
      head_first_r  <= head_first_nxt;
      head_second_r <= head_second_nxt;
      tail_value_r  <= tail_value_nxt;
    end
  end

  assign cfg.head_first  = head_first_r;
  assign cfg.head_second = head_second_r;
  assign cfg.tail_value  = tail_value_r;
  assign cfg.wr          = apb_wr;

  // input queue with tail tagging at intake
  assign in_ready = (cnt_r != (xcfd_pkg::QUEUE_AW+1)'(xcfd_pkg::QUEUE_DEPTH));
  assign push     = in_valid & in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = qmem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r].rx_byte <= in_rx_byte;
      qmem_r[wr_ptr_r].is_tail <= (in_rx_byte == tail_value_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/xcfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_back: frame parser over the receive buffer
// Appends queued bytes to a ring buffer in ram, hunts for the header, checks
// length, tail and xor check, and streams results through an output register.
// ----------------------------------------------------------------------------
module xcfd_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire xcfd_pkg::cfg_t          cfg,
  input  wire                          q_valid,
  input  wire xcfd_pkg::qent_t         q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output xcfd_pkg::result_t            out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HDR,
    S_TAIL,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  xcfd_pkg::ptr_t              base_r, base_nxt;
  xcfd_pkg::ptr_t              fill_r, fill_nxt;
  xcfd_pkg::ptr_t              rd_ofs_r, rd_ofs_nxt;
  xcfd_pkg::ptr_t              q_ofs_r, q_ofs_nxt;
  logic                        q_ok_r, q_ok_nxt;
  logic                        synced_r, synced_nxt;
  logic [xcfd_pkg::BYTE_W-1:0] type_r, type_nxt;
  xcfd_pkg::ptr_t              len_r, len_nxt;
  logic [xcfd_pkg::BYTE_W-1:0] prev_r, prev_nxt;
  logic [xcfd_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic                        bad_r, bad_nxt;
  logic [xcfd_pkg::IDX_W-1:0]  k_r, k_nxt;
  logic                        out_valid_r, out_valid_nxt;
  xcfd_pkg::result_t           out_r, out_nxt;

  logic                        ram_re;
  logic [xcfd_pkg::BYTE_W-1:0] q_byte;
  xcfd_pkg::ptr_t              fill_inc, plen, head_ofs, fill_after_head;
  xcfd_pkg::ptr_t              len_in, plen_in, chk_end;
  logic [xcfd_pkg::BYTE_W-1:0] xor_in, type_len_xor;
  logic                        last_k, out_free, load_out;
  xcfd_pkg::result_t           res_new;
  logic                        drop_en;
  xcfd_pkg::ptr_t              drop_n, drop_from, drop_left;

  // receive buffer
  xcfd_ram #(
    .WIDTH (xcfd_pkg::BYTE_W),
    .DEPTH (xcfd_pkg::RAM_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (q_pop),
    .waddr (base_r + fill_r),
    .wdata (q_head.rx_byte),
    .re    (ram_re),
    .raddr (base_r + rd_ofs_r),
    .rdata (q_byte)
  );

  // shared arithmetic
  assign fill_inc        = fill_r + xcfd_pkg::ptr_t'(1);
  assign plen            = len_r + xcfd_pkg::MIN_FRAME_P;
  assign head_ofs        = q_ofs_r - xcfd_pkg::ptr_t'(1);
  assign fill_after_head = fill_r - head_ofs;
  assign len_in          = q_byte[xcfd_pkg::RAM_AW-1:0];
  assign plen_in         = len_in + xcfd_pkg::MIN_FRAME_P;
  assign chk_end         = len_r + xcfd_pkg::OFS_PAYLOAD_P;
  assign xor_in          = xor_r ^ q_byte;
  assign type_len_xor    = type_r ^ xcfd_pkg::BYTE_W'(len_r);
  assign last_k          = (xcfd_pkg::ptr_t'(k_r) + xcfd_pkg::ptr_t'(1) == len_r);
  assign out_free        = !out_valid_r || out_ready;
  assign drop_left       = drop_from - drop_n;

  // parser control
  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    fill_nxt   = fill_r;
    rd_ofs_nxt = rd_ofs_r;
    q_ofs_nxt  = q_ofs_r;
    q_ok_nxt   = q_ok_r;
    synced_nxt = synced_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    prev_nxt   = prev_r;
    xor_nxt    = xor_r;
    bad_nxt    = bad_r;
    k_nxt      = k_r;
    ram_re     = 1'b0;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    res_new    = '0;
    drop_en    = 1'b0;
    drop_n     = '0;
    drop_from  = fill_r;

    unique case (state_r)
      // append one byte, then decide whether any parsing is due
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          fill_nxt = fill_inc;
          if (fill_inc >= xcfd_pkg::MIN_FRAME_P) begin
            if (synced_r) begin
              if (fill_inc == plen) begin
                if (q_head.is_tail) begin
                  state_nxt  = S_CHECK;
                  rd_ofs_nxt = xcfd_pkg::OFS_PAYLOAD_P;
                  q_ok_nxt   = 1'b0;
                  xor_nxt    = type_len_xor;
                end else begin
                  drop_en   = 1'b1;
                  drop_n    = xcfd_pkg::HDR_BYTES_P;
                  drop_from = fill_inc;
                end
              end
            end else begin
              state_nxt  = S_SCAN;
              rd_ofs_nxt = '0;
              q_ok_nxt   = 1'b0;
            end
          end
        end
      end

      // header hunt, one buffered byte per cycle
      S_SCAN: begin
        ram_re     = 1'b1;
        rd_ofs_nxt = rd_ofs_r + xcfd_pkg::ptr_t'(1);
        q_ok_nxt   = 1'b1;
        q_ofs_nxt  = rd_ofs_r;
        if (q_ok_r) begin
          prev_nxt = q_byte;
          if (q_ofs_r != '0 && prev_r == cfg.head_first && q_byte == cfg.head_second) begin
            base_nxt = base_r + head_ofs;
            fill_nxt = fill_after_head;
            if (fill_after_head < xcfd_pkg::TYPE_LEN_END_P) begin
              synced_nxt = 1'b0;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt  = S_HDR;
              rd_ofs_nxt = xcfd_pkg::OFS_TYPE_P;
              q_ok_nxt   = 1'b0;
            end
          end else if (q_ofs_r == fill_r - xcfd_pkg::ptr_t'(1)) begin
            // no header anywhere: keep only the newest byte
            base_nxt   = base_r + q_ofs_r;
            fill_nxt   = xcfd_pkg::ptr_t'(1);
            synced_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end

      // type and length bytes
      S_HDR: begin
        ram_re     = 1'b1;
        rd_ofs_nxt = rd_ofs_r + xcfd_pkg::ptr_t'(1);
        q_ok_nxt   = 1'b1;
        q_ofs_nxt  = rd_ofs_r;
        if (q_ok_r) begin
          if (q_ofs_r == xcfd_pkg::OFS_TYPE_P) begin
            type_nxt = q_byte;
          end else if (q_ofs_r == xcfd_pkg::OFS_LEN_P) begin
            if (q_byte > xcfd_pkg::MAX_LEN_B) begin
              drop_en = 1'b1;
              drop_n  = xcfd_pkg::HDR_BYTES_P;
            end else begin
              len_nxt = len_in;
              if (fill_r < plen_in) begin
                synced_nxt = 1'b1;
                state_nxt  = S_IDLE;
              end else begin
                state_nxt  = S_TAIL;
                rd_ofs_nxt = plen_in - xcfd_pkg::ptr_t'(1);
                q_ok_nxt   = 1'b0;
              end
            end
          end
        end
      end

      // tail byte of a fully buffered frame
      S_TAIL: begin
        ram_re    = 1'b1;
        q_ok_nxt  = 1'b1;
        q_ofs_nxt = rd_ofs_r;
        if (q_ok_r) begin
          if (q_byte == cfg.tail_value) begin
            state_nxt  = S_CHECK;
            rd_ofs_nxt = xcfd_pkg::OFS_PAYLOAD_P;
            q_ok_nxt   = 1'b0;
            xor_nxt    = type_len_xor;
          end else begin
            drop_en = 1'b1;
            drop_n  = xcfd_pkg::HDR_BYTES_P;
          end
        end
      end

      // xor over type, length, payload and check byte, zero when good
      S_CHECK: begin
        ram_re     = 1'b1;
        rd_ofs_nxt = rd_ofs_r + xcfd_pkg::ptr_t'(1);
        q_ok_nxt   = 1'b1;
        q_ofs_nxt  = rd_ofs_r;
        if (q_ok_r) begin
          xor_nxt = xor_in;
          if (q_ofs_r == chk_end) begin
            bad_nxt    = (xor_in != '0);
            state_nxt  = S_EMIT;
            k_nxt      = '0;
            rd_ofs_nxt = xcfd_pkg::OFS_PAYLOAD_P;
            q_ok_nxt   = 1'b0;
          end
        end
      end

      // results into the output register
      S_EMIT: begin
        res_new.frame_type   = type_r;
        res_new.frame_length = xcfd_pkg::LEN_W'(len_r);
        if (bad_r || len_r == '0) begin
          if (out_free) begin
            load_out              = 1'b1;
            res_new.frame_status  = bad_r;
            res_new.last_of_frame = 1'b1;
            drop_en               = 1'b1;
            drop_n                = plen;
          end
        end else begin
          if (!q_ok_r || out_free) begin
            ram_re     = 1'b1;
            rd_ofs_nxt = rd_ofs_r + xcfd_pkg::ptr_t'(1);
            q_ok_nxt   = 1'b1;
            q_ofs_nxt  = rd_ofs_r;
          end
          if (q_ok_r && out_free) begin
            load_out              = 1'b1;
            res_new.payload_byte  = q_byte;
            res_new.byte_index    = k_r;
            res_new.has_payload   = 1'b1;
            res_new.last_of_frame = last_k;
            k_nxt                 = k_r + 1'b1;
            if (last_k) begin
              drop_en = 1'b1;
              drop_n  = plen;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // drop bytes from the buffer front and rescan if enough remain
    if (drop_en) begin
      base_nxt   = base_r + drop_n;
      fill_nxt   = drop_left;
      synced_nxt = 1'b0;
      rd_ofs_nxt = '0;
      q_ok_nxt   = 1'b0;
      state_nxt  = (drop_left >= xcfd_pkg::MIN_FRAME_P) ? S_SCAN : S_IDLE;
    end

    // new header values invalidate a known frame start
    if (cfg.wr) begin
      synced_nxt = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_nxt = out_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_new;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      fill_r      <= '0;
      rd_ofs_r    <= '0;
      q_ofs_r     <= '0;
      q_ok_r      <= 1'b0;
      synced_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      fill_r      <= fill_nxt;
      rd_ofs_r    <= rd_ofs_nxt;
      q_ofs_r     <= q_ofs_nxt;
      q_ok_r      <= q_ok_nxt;
      synced_r    <= synced_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r <= type_nxt;
    len_r  <= len_nxt;
    prev_r <= prev_nxt;
    xor_r  <= xor_nxt;
    bad_r  <= bad_nxt;
    k_r    <= k_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // buffer never grows past one maximal frame
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= xcfd_pkg::STORE_DEPTH_P)
    else $error("receive buffer fill above its depth");

  // a known frame start always carries a legal length
  a_synced_len: assert property (@(posedge clk) disable iff (!rst_n)
    synced_r |-> len_r <= xcfd_pkg::MAX_LEN_P)
    else $error("frame start marked with illegal length");

  // header hunt only runs on a buffer that can hold a frame
  a_scan_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> fill_r >= xcfd_pkg::MIN_FRAME_P)
    else $error("header hunt on a short buffer");

  // results appear only out of the emission phase
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result loaded outside emission");

endmodule
`default_nettype wire
